FILE: hw/rtl/beacon_presence_hysteresis_counter_assert.svh
// assertion macros of the beacon presence counter checker
`ifndef BEACON_PRESENCE_HYSTERESIS_COUNTER_ASSERT_SVH
`define BEACON_PRESENCE_HYSTERESIS_COUNTER_ASSERT_SVH

// property checked on every clock edge outside reset
`define BPHC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BPHC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bphc_pkg.sv
// shared types and constants of the beacon presence hysteresis counter
package bphc_pkg;

    // beacon field widths
    localparam int MAC_BYTES = 6;
    localparam int MAC_W     = 8 * MAC_BYTES;
    localparam int LVL_W     = 12;
    localparam int CNT_OUT_W = 5;

    // table and queue sizing
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int QUEUE_DEPTH     = 2;

    // configuration port
    localparam int REG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic signed [LVL_W-1:0] t_level;

    localparam t_level ENTER_RESET = -12'sd700;
    localparam t_level EXIT_RESET  = -12'sd750;

    // register indexes
    typedef enum logic [0:0] {
        REG_ENTER = 1'b0,
        REG_EXIT  = 1'b1
    } t_reg;

    // input transaction payload
    typedef struct packed {
        logic             entry_present;
        logic [MAC_W-1:0] beacon_mac;
        t_level           signal_level;
        logic             snapshot_end;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic [CNT_OUT_W-1:0] near_count;
        logic [CNT_OUT_W-1:0] tracked_count;
    } t_out_item;

    // command kinds handed from front to back
    typedef enum logic [1:0] {
        OP_UPDATE       = 2'd0,
        OP_CLOSE        = 2'd1,
        OP_UPDATE_CLOSE = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [MAC_W-1:0] mac;
        t_level           level;
    } t_cmd;

    // table engine states
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_SEARCH  = 2'd1,
        ST_COMPACT = 2'd2,
        ST_FINISH  = 2'd3
    } t_back_state;

endpackage

FILE: hw/rtl/bphc_queue.sv
// short command queue between the front and the table engine
module bphc_queue
    import bphc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [FW-1:0] r_fill;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_fill != FW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + FW'(1);
                2'b01:   r_fill <= r_fill - FW'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: hw/rtl/bphc_front.sv
// input stage: accepts beacon items and turns them into table commands
module bphc_front
    import bphc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    logic r_vld;
    t_cmd r_cmd;
    t_op  op;
    logic keep;
    logic accept;
    logic push;

    // classify the item; items with no entry and no end mark do nothing
    always_comb begin
        op   = OP_UPDATE;
        keep = 1'b1;
        unique case ({i_in_data.entry_present, i_in_data.snapshot_end})
            2'b10:   op = OP_UPDATE;
            2'b01:   op = OP_CLOSE;
            2'b11:   op = OP_UPDATE_CLOSE;
            default: keep = 1'b0;
        endcase
    end

    assign o_in_ready  = !r_vld || i_cmd_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign push        = r_vld && i_cmd_ready;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (push) begin
                r_vld <= 1'b0;
            end
            if (accept && keep) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_cmd.op    <= op;
            r_cmd.mac   <= i_in_data.beacon_mac;
            r_cmd.level <= i_in_data.signal_level;
        end
    end

endmodule

FILE: hw/rtl/bphc_back.sv
// table engine: lookup, append, hysteresis update and end-of-snapshot compaction
module bphc_back
    import bphc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_level    i_enter,
    input  t_level    i_exit,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_back_state r_state;
    t_back_state n_state;

    // mac storage, one read and one write per cycle
    logic [MAC_W-1:0]       r_mem [TABLE_DEPTH];
    logic [MAC_W-1:0]       r_mem_q;
    logic [TABLE_DEPTH-1:0] r_near;
    logic [TABLE_DEPTH-1:0] r_seen;

    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_idx;
    logic             r_cmp_vld;
    logic [AW-1:0]    r_cmp_idx;
    logic [CW-1:0]    r_wr_ptr;
    logic [CW-1:0]    r_nears;
    logic [MAC_W-1:0] r_mac;
    t_level           r_lvl;
    logic             r_close;
    logic             r_out_vld;
    t_out_item        r_out;

    logic             hit;
    logic             scan_left;
    logic             room;
    logic             miss_done;
    logic             compact_done;
    logic             rd_en;
    logic             pop;
    logic             out_free;
    logic             upd_en;
    logic [AW-1:0]    slot;
    logic             near_old;
    logic             near_new;
    logic             copy_en;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [MAC_W-1:0] mem_wdata;
    logic [CW+CNT_OUT_W-1:0] nears_ext;
    logic [CW+CNT_OUT_W-1:0] kept_ext;

    // scan status
    assign hit          = r_cmp_vld && (r_mem_q == r_mac);
    assign scan_left    = (r_idx < r_cnt);
    assign room         = (r_cnt < CW'(TABLE_DEPTH));
    assign miss_done    = !hit && !scan_left;
    assign compact_done = !scan_left && !r_cmp_vld;
    assign out_free     = !r_out_vld || i_out_ready;
    assign pop          = i_cmd_valid && o_cmd_ready;

    // hysteresis on the matched or freshly appended slot
    assign slot     = hit ? r_cmp_idx : r_cnt[AW-1:0];
    assign near_old = hit ? r_near[r_cmp_idx] : 1'b0;
    assign upd_en   = (r_state == ST_SEARCH) && (hit || (miss_done && room));
    always_comb begin
        if (r_lvl >= i_enter) begin
            near_new = 1'b1;
        end else if (r_lvl < i_exit) begin
            near_new = 1'b0;
        end else begin
            near_new = near_old;
        end
    end

    // kept entry during compaction
    assign copy_en = (r_state == ST_COMPACT) && r_cmp_vld && r_seen[r_cmp_idx];

    // single write port shared by append and compaction
    assign mem_we    = (upd_en && !hit) || copy_en;
    assign mem_waddr = copy_en ? r_wr_ptr[AW-1:0] : r_cnt[AW-1:0];
    assign mem_wdata = copy_en ? r_mem_q : r_mac;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.op == OP_CLOSE) ? ST_COMPACT : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit || miss_done) begin
                    n_state = r_close ? ST_COMPACT : ST_IDLE;
                end
            end
            ST_COMPACT: begin
                if (compact_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_ready = 1'b0;
        rd_en       = 1'b0;
        unique case (r_state)
            ST_IDLE:    o_cmd_ready = 1'b1;
            ST_SEARCH:  rd_en = scan_left && !hit;
            ST_COMPACT: rd_en = scan_left;
            ST_FINISH:  rd_en = 1'b0;
            default:    rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // mac memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_idx[AW-1:0]];
        end
    end

    // latch the command being worked on
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_mac   <= i_cmd.mac;
            r_lvl   <= i_cmd.level;
            r_close <= (i_cmd.op != OP_UPDATE);
        end
    end

    // scan counters, flags and table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
            r_wr_ptr  <= '0;
            r_nears   <= '0;
            r_near    <= '0;
            r_seen    <= '0;
        end else begin
            // read pipeline of the scan
            if (rd_en) begin
                r_cmp_vld <= 1'b1;
                r_cmp_idx <= r_idx[AW-1:0];
                r_idx     <= r_idx + CW'(1);
            end else begin
                r_cmp_vld <= 1'b0;
            end
            // lookup result
            if (upd_en) begin
                r_near[slot] <= near_new;
                r_seen[slot] <= 1'b1;
                if (!hit) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            // compaction copy
            if (copy_en) begin
                r_near[r_wr_ptr[AW-1:0]] <= r_near[r_cmp_idx];
                r_wr_ptr <= r_wr_ptr + CW'(1);
                r_nears  <= r_nears + CW'(r_near[r_cmp_idx]);
            end
            // snapshot closed
            if (r_state == ST_FINISH && out_free) begin
                r_cnt  <= r_wr_ptr;
                r_seen <= '0;
            end
            // fresh scan on entering search or compaction
            if (n_state != r_state &&
                (n_state == ST_SEARCH || n_state == ST_COMPACT)) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_wr_ptr  <= '0;
                r_nears   <= '0;
            end
        end
    end

    // result register, counts cut to the field width
    assign nears_ext = {{CNT_OUT_W{1'b0}}, r_nears};
    assign kept_ext  = {{CNT_OUT_W{1'b0}}, r_wr_ptr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_out.near_count    <= nears_ext[CNT_OUT_W-1:0];
            r_out.tracked_count <= kept_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/beacon_presence_hysteresis_counter.sv
// top level of the beacon presence hysteresis counter
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one beacon entry
// per transaction: MAC, RSSI in tenths of a dBm, an entry flag and an end mark.
// A transaction with the end mark closes the snapshot and yields exactly one
// result transaction (near count, tracked count) on the output channel
// (o_out_valid / i_out_ready / o_out_data); all others yield none.
// The thresholds sit behind an APB-style port: enter at 0x0, exit at 0x4.
// An item passes a command register and a two-entry queue, then the table
// engine scans the stored MACs through a registered memory read: an entry
// item is compared against the tracked MACs until a match or the end of the
// table, and a closing item adds a compaction pass before the result shows.
// The scan of the table sets the rate.
// The front keeps accepting while the engine is busy, until the queue fills.
// A result waiting on a stalled receiver holds in the output register; the
// engine still processes further entries and only the next close waits.
// Reset empties the table, clears all flags and restores the thresholds
// to -70.0 and -75.0 dBm; the MAC store itself needs no clearing.
module beacon_presence_hysteresis_counter
    import bphc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_level r_enter;
    t_level r_exit;
    t_reg   reg_sel;
    logic   cfg_wr;

    logic   f_cmd_valid;
    logic   f_cmd_ready;
    t_cmd   f_cmd;
    logic   q_cmd_valid;
    logic   q_cmd_ready;
    t_cmd   q_cmd;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter <= ENTER_RESET;
            r_exit  <= EXIT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ENTER: r_enter <= pwdata[LVL_W-1:0];
                REG_EXIT:  r_exit  <= pwdata[LVL_W-1:0];
                default:   r_enter <= r_enter;
            endcase
        end
    end

    // register read-back, sign extended
    always_comb begin
        unique case (reg_sel)
            REG_ENTER: prdata = {{(APB_DATA_W - LVL_W){r_enter[LVL_W-1]}}, r_enter};
            REG_EXIT:  prdata = {{(APB_DATA_W - LVL_W){r_exit[LVL_W-1]}}, r_exit};
            default:   prdata = '0;
        endcase
    end

    bphc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (f_cmd_valid),
        .i_cmd_ready (f_cmd_ready),
        .o_cmd       (f_cmd)
    );

    bphc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_cmd_valid),
        .o_push_ready (f_cmd_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_cmd_valid),
        .i_pop_ready  (q_cmd_ready),
        .o_pop_cmd    (q_cmd)
    );

    bphc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enter     (r_enter),
        .i_exit      (r_exit),
        .i_cmd_valid (q_cmd_valid),
        .o_cmd_ready (q_cmd_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hw/rtl/bphc_checker.sv
// port-level checks of the beacon presence counter, bound to the top level
`include "beacon_presence_hysteresis_counter_assert.svh"

module bphc_checker
    import bphc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // a stalled result stays offered
    `BPHC_ASSERT_RST(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // a stalled result keeps its value
    `BPHC_ASSERT_RST(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_out_data), "result changed while stalled")

    // near entries are a subset of the kept entries
    `BPHC_ASSERT_RST(a_near_le_kept, o_out_valid |-> (o_out_data.near_count <= o_out_data.tracked_count) || (TABLE_DEPTH > 31), "near count above tracked count")

    // never more kept entries than table slots
    `BPHC_ASSERT_RST(a_kept_le_depth, o_out_valid |-> (32'(o_out_data.tracked_count) <= TABLE_DEPTH), "tracked count above table depth")

    // no result right after reset
    `BPHC_ASSERT_ALWAYS(a_reset_quiet, i_rst_n && $past(!i_rst_n) |-> !o_out_valid, "result offered after reset")

endmodule

bind beacon_presence_hysteresis_counter bphc_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/sv/testbench.sv
// self-checking testbench for the beacon presence hysteresis counter
module testbench;
    import bphc_pkg::*;

    localparam int TBL          = DEF_TABLE_DEPTH;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 850;
    localparam int MAC_POOL     = 24;
    localparam int LVL_LOW      = -1280;
    localparam int LVL_HIGH     = 1270;

    // clock, reset and block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [REG_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // stimulus and result bookkeeping
    t_in_item  pending_items[$];
    t_out_item expected_counts[$];
    int        items_queued   = 0;
    int        items_accepted = 0;
    int        random_items   = 0;
    int        send_gap       = 0;
    int        recv_wait      = 0;
    int        cycle_count    = 0;
    logic      in_fire        = 1'b0;
    logic      out_fire       = 1'b0;
    logic      failed         = 1'b0;
    logic      idle_on        = 1'b1;

    // shadow of the tracking table
    logic [MAC_W-1:0] mac_store [TBL];
    logic             near_flag [TBL];
    logic             seen_mark [TBL];
    int               tracked     = 0;
    t_level           enter_level = ENTER_RESET;
    t_level           exit_level  = EXIT_RESET;

    logic [MAC_W-1:0] mac_pool [MAC_POOL];

    beacon_presence_hysteresis_counter #(
        .TABLE_DEPTH(TBL)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    // table update for one beacon transaction, closing the snapshot on the end mark
    function automatic void track_beacon(input t_in_item it);
        int        k;
        int        slot;
        int        kept;
        int        nears;
        t_level    lvl;
        t_out_item res;
        slot = TBL;
        lvl  = it.signal_level;
        if (it.entry_present) begin
            for (k = 0; k < tracked; k++) begin
                if (slot == TBL && mac_store[k] == it.beacon_mac) slot = k;
            end
            // new mac goes at the end if there is room
            if (slot == TBL && tracked < TBL) begin
                slot            = tracked;
                tracked         = tracked + 1;
                mac_store[slot] = it.beacon_mac;
                near_flag[slot] = 1'b0;
            end
            // enter test wins over the exit test
            if (slot < TBL) begin
                if (lvl >= enter_level) near_flag[slot] = 1'b1;
                else if (lvl < exit_level) near_flag[slot] = 1'b0;
                seen_mark[slot] = 1'b1;
            end
        end
        if (it.snapshot_end) begin
            kept  = 0;
            nears = 0;
            // drop unseen entries, keep order
            for (k = 0; k < tracked; k++) begin
                if (seen_mark[k]) begin
                    mac_store[kept] = mac_store[k];
                    near_flag[kept] = near_flag[k];
                    if (near_flag[k]) nears++;
                    kept++;
                end
            end
            tracked = kept;
            for (k = 0; k < TBL; k++) seen_mark[k] = 1'b0;
            res.near_count    = CNT_OUT_W'(nears);
            res.tracked_count = CNT_OUT_W'(kept);
            expected_counts.push_back(res);
        end
    endfunction

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, 3)) : 0;
    endfunction

    function automatic t_level clamp_level(input int v);
        return t_level'((v < LVL_LOW) ? LVL_LOW : (v > LVL_HIGH) ? LVL_HIGH : v);
    endfunction

    function automatic t_level rand_level();
        return t_level'(int'($urandom_range(0, LVL_HIGH - LVL_LOW)) + LVL_LOW);
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // levels cluster around the thresholds to exercise the hysteresis band
    function automatic t_level pick_level();
        case ($urandom_range(0, 3))
            0: return clamp_level(int'(enter_level) + int'($urandom_range(0, 6)) - 3);
            1: return clamp_level(int'(exit_level) + int'($urandom_range(0, 6)) - 3);
            default: return rand_level();
        endcase
    endfunction

    function automatic void post_beacon(input logic present, input logic [MAC_W-1:0] mac,
                                        input t_level lvl, input logic last);
        t_in_item it;
        it.entry_present = present;
        it.beacon_mac    = mac;
        it.signal_level  = lvl;
        it.snapshot_end  = last;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    // one well-formed snapshot with occasional ignored transactions mixed in
    function automatic void queue_snapshot(input int size, input logic distinct);
        int               k;
        logic             end_on_entry;
        logic [MAC_W-1:0] mac;
        if (size == 0) begin
            post_beacon(1'b0, random_mac(), rand_level(), 1'b1);
            random_items++;
            return;
        end
        end_on_entry = 1'($urandom_range(0, 1));
        for (k = 0; k < size; k++) begin
            if ($urandom_range(0, 9) == 0) post_beacon(1'b0, random_mac(), rand_level(), 1'b0);
            if (distinct) mac = mac_pool[k % MAC_POOL];
            else if ($urandom_range(0, 15) == 0) mac = random_mac();
            else mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
            post_beacon(1'b1, mac, pick_level(), end_on_entry && (k == size - 1));
            random_items++;
        end
        if (!end_on_entry) begin
            post_beacon(1'b0, random_mac(), rand_level(), 1'b1);
            random_items++;
        end
    endfunction

    // register write, setup then access phase
    task automatic write_threshold(input t_reg idx, input t_level value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_W'(4 * int'(idx));
        pwdata  <= APB_DATA_W'(int'(value));
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ENTER) enter_level = value;
        else exit_level = value;
    endtask

    task automatic wait_drained();
        wait (items_accepted == items_queued);
        wait (expected_counts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input side: sample the handshake and predict on every accepted transaction
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            track_beacon(i_in_data);
            items_accepted <= items_accepted + 1;
        end
    end

    // input driver, fed from the pending queue
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (in_fire) send_gap = draw_gap();
            if (send_gap > 0) begin
                send_gap   = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver may stall after each result transaction
    always @(negedge i_clk) begin
        if (out_fire) recv_wait = draw_gap();
        if (recv_wait > 0) begin
            recv_wait   = recv_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        out_fire <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected result transaction: near_count %0d, tracked_count %0d",
                       o_out_data.near_count, o_out_data.tracked_count);
                failed = 1'b1;
            end else begin
                want = expected_counts.pop_front();
                if (o_out_data.near_count !== want.near_count) begin
                    $error("near_count mismatch: expected %0d, actual %0d",
                           want.near_count, o_out_data.near_count);
                    failed = 1'b1;
                end
                if (o_out_data.tracked_count !== want.tracked_count) begin
                    $error("tracked_count mismatch: expected %0d, actual %0d",
                           want.tracked_count, o_out_data.tracked_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("beacon_presence_hysteresis_counter verification failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin : stimulus
        int     k;
        int     phase;
        int     phase_end;
        int     size;
        t_level new_enter;
        t_level new_exit;
        for (k = 0; k < TBL; k++) begin
            mac_store[k] = '0;
            near_flag[k] = 1'b0;
            seen_mark[k] = 1'b0;
        end
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (k = 2; k < MAC_POOL; k++) mac_pool[k] = random_mac();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset thresholds
        post_beacon(1'b0, '0, '0, 1'b1);                       // empty snapshot on empty table
        post_beacon(1'b0, '1, -12'sd1, 1'b0);                   // nothing, not last
        post_beacon(1'b1, '0, -12'sd700, 1'b0);                 // exactly enter: near
        post_beacon(1'b1, '1, 12'sd1270, 1'b1);                 // entry with end mark
        post_beacon(1'b1, '0, -12'sd701, 1'b0);                 // inside band: hold
        post_beacon(1'b1, '1, -12'sd750, 1'b0);                 // exactly exit: hold
        post_beacon(1'b1, 48'h0123_4567_89AB, -12'sd1280, 1'b0);
        post_beacon(1'b0, 48'hFEDC_BA98_7654, 12'sd1270, 1'b1); // end without entry
        post_beacon(1'b1, '0, -12'sd751, 1'b0);                 // below exit: clear
        post_beacon(1'b1, '0, -12'sd700, 1'b0);                 // repeat in same snapshot
        post_beacon(1'b1, '1, -12'sd751, 1'b1);                 // unseen mac dropped
        post_beacon(1'b0, '0, '0, 1'b1);                        // empty snapshot clears table
        post_beacon(1'b1, 48'hA5A5_A5A5_A5A5, -12'sd1280, 1'b0);
        post_beacon(1'b1, 48'h5A5A_5A5A_5A5A, 12'sd1, 1'b1);
        post_beacon(1'b1, 48'hA5A5_A5A5_A5A5, 12'sd1270, 1'b1);
        wait_drained();

        // random phases, each under its own threshold setting
        phase = 0;
        while (items_queued < RANDOM_ITEMS - 50) begin
            case (phase)
                0: begin new_enter = clamp_level(LVL_LOW);  new_exit = clamp_level(LVL_LOW);  end
                1: begin new_enter = clamp_level(LVL_HIGH); new_exit = clamp_level(LVL_HIGH); end
                2: begin new_enter = -12'sd800;             new_exit = -12'sd600;             end
                3: begin new_enter = clamp_level(LVL_HIGH); new_exit = clamp_level(LVL_LOW);  end
                4: begin new_enter = clamp_level(LVL_LOW);  new_exit = clamp_level(LVL_HIGH); end
                default: begin
                    new_enter = rand_level();
                    if ($urandom_range(0, 3) == 0) new_exit = rand_level();
                    else new_exit = clamp_level(int'(new_enter) - int'($urandom_range(0, 100)));
                end
            endcase
            write_threshold(REG_ENTER, new_enter);
            write_threshold(REG_EXIT, new_exit);
            idle_on   = (phase % 3) != 2;
            phase_end = random_items + 100;
            // open with a full table so the overflow path is hit
            queue_snapshot(20, 1'b1);
            while (random_items < phase_end) begin
                if ($urandom_range(0, 7) == 0) size = $urandom_range(12, 20);
                else size = $urandom_range(0, 6);
                queue_snapshot(size, 1'b0);
            end
            wait_drained();
            phase++;
        end

        if (failed) begin
            $display("beacon_presence_hysteresis_counter verification failed");
        end else begin
            $display("beacon_presence_hysteresis_counter verification clean");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bphc_pkg.sv
hw/rtl/bphc_queue.sv
hw/rtl/bphc_front.sv
hw/rtl/bphc_back.sv
hw/rtl/beacon_presence_hysteresis_counter.sv
hw/rtl/bphc_checker.sv
tb/sv/testbench.sv
